FILE: sv/ftma_pkg.sv
// Shared widths, constants and control structures of the frame time moving average.
`timescale 1ns / 1ps

package ftma_pkg;

  localparam int SPAN_W    = 40;
  localparam int AVG_W     = 39;
  localparam int FPS_W     = 38;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 80;
  localparam int M_TUSER_W = 2;

  // Frames per second in Q.8 is this numerator divided by the mean span in ns.
  localparam logic [FPS_W-1:0] FPS_NUM = 38'd256000000000;

  typedef struct packed {
    logic load;
    logic sub_old;
    logic add_new;
    logic div_start;
    logic div_fps;
    logic take_mean;
    logic take_fps;
    logic clear_result;
    logic out_load;
  } ftma_cmd_t;

  typedef struct packed {
    logic empty;
    logic div_busy;
  } ftma_sts_t;

endpackage

FILE: sv/ftma_div.sv
// Iterative restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module ftma_div #(
  parameter int DIVIDEND_W = 46,
  parameter int DIVISOR_W  = 39
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;

  assign rem_sh   = {rem, quo[DIVIDEND_W-1]};
  assign diff     = rem_sh - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(DIVIDEND_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[DIVISOR_W]) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[DIVISOR_W-1:0];
        quo <= {quo[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: sv/ftma_dp.sv
// Datapath: span ring memory, running sum, sample count, shared divider and result register.
`timescale 1ns / 1ps

module ftma_dp #(
  parameter int SAMPLE_COUNT = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  ftma_pkg::ftma_cmd_t              cmd,
  output ftma_pkg::ftma_sts_t              sts,
  input  logic [ftma_pkg::S_TDATA_W-1:0]   s_tdata,
  output logic [ftma_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [ftma_pkg::M_TUSER_W-1:0]   m_tuser
);

  import ftma_pkg::*;

  localparam int SLOT_W  = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
  localparam int COUNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam int SUM_W   = AVG_W + COUNT_W;
  localparam int DIV_W   = (SUM_W > FPS_W) ? SUM_W : FPS_W;

  logic [AVG_W-1:0]   ring [SAMPLE_COUNT];
  logic [SPAN_W-1:0]  span;
  logic [AVG_W-1:0]   old_span;
  logic [SUM_W-1:0]   sum;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] count;
  logic [AVG_W-1:0]   mean;
  logic [FPS_W-1:0]   fps;
  logic               positive;
  logic               full;
  logic [DIV_W-1:0]   div_dividend;
  logic [AVG_W-1:0]   div_divisor;
  logic [DIV_W-1:0]   div_quotient;
  logic               div_busy;

  assign positive = !span[SPAN_W-1] && (span != '0);
  assign full     = (count == COUNT_W'(SAMPLE_COUNT));

  assign sts.empty    = (count == '0);
  assign sts.div_busy = div_busy;

  // The ring is read at the write slot when the word is taken and written at that slot when the new span is added.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      old_span <= ring[slot];
    end
    if (cmd.add_new && positive) begin
      ring[slot] <= span[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      slot  <= '0;
      count <= '0;
    end else begin
      if (cmd.sub_old && positive && full) begin
        sum <= sum - SUM_W'(old_span);
      end else if (cmd.add_new && positive) begin
        sum <= sum + SUM_W'(span[AVG_W-1:0]);
        if (slot == SLOT_W'(SAMPLE_COUNT - 1)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
        if (!full) begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign div_dividend = cmd.div_fps ? DIV_W'(FPS_NUM) : DIV_W'(sum);
  assign div_divisor  = cmd.div_fps ? mean : AVG_W'(count);

  ftma_div #(
    .DIVIDEND_W(DIV_W),
    .DIVISOR_W (AVG_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .quotient(div_quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      span <= s_tdata[SPAN_W-1:0];
    end
    if (cmd.clear_result) begin
      mean <= '0;
      fps  <= '0;
    end else begin
      if (cmd.take_mean) begin
        mean <= div_quotient[AVG_W-1:0];
      end
      if (cmd.take_fps) begin
        fps <= div_quotient[FPS_W-1:0];
      end
    end
    if (cmd.out_load) begin
      m_tdata <= {(M_TDATA_W - AVG_W - FPS_W)'(0), fps, mean};
      m_tuser <= {(count != '0), positive};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= COUNT_W'(SAMPLE_COUNT))
    else $error("sample count exceeds ring depth");
  assert property (@(posedge clk) disable iff (rst) !full |-> (COUNT_W'(slot) == count))
    else $error("write slot out of step with sample count while filling");
  assert property (@(posedge clk) disable iff (rst) (count == '0) |-> (sum == '0))
    else $error("running sum nonzero with empty ring");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

FILE: sv/ftma_ctrl.sv
// Controller state machine that sequences the update and, unless the ring is empty, the two divisions per word.
`timescale 1ns / 1ps

module ftma_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  ftma_pkg::ftma_sts_t sts,
  output ftma_pkg::ftma_cmd_t cmd
);

  import ftma_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    UPD_SUB,
    UPD_ADD,
    CHECK,
    DIV_MEAN,
    START_FPS,
    DIV_FPS,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = UPD_SUB;
        end
      end
      UPD_SUB: begin
        cmd.sub_old = 1'b1;
        state_next  = UPD_ADD;
      end
      UPD_ADD: begin
        cmd.add_new = 1'b1;
        state_next  = CHECK;
      end
      CHECK: begin
        if (sts.empty) begin
          cmd.clear_result = 1'b1;
          state_next       = FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = DIV_MEAN;
        end
      end
      DIV_MEAN: begin
        if (!sts.div_busy) begin
          cmd.take_mean = 1'b1;
          state_next    = START_FPS;
        end
      end
      START_FPS: begin
        cmd.div_start = 1'b1;
        cmd.div_fps   = 1'b1;
        state_next    = DIV_FPS;
      end
      DIV_FPS: begin
        if (!sts.div_busy) begin
          cmd.take_fps = 1'b1;
          state_next   = FINISH;
        end
      end
      FINISH: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cmd.load |=> (state == UPD_SUB))
    else $error("accepted word did not start the update");
  assert property (@(posedge clk) disable iff (rst)
                   (m_tvalid && !m_tready) |-> !cmd.out_load)
    else $error("result register overwritten while stalled");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |=> sts.div_busy)
    else $error("divider did not start");

endmodule

FILE: sv/frame_time_moving_average.sv
// Top level of the frame time moving average: controller plus datapath.
`timescale 1ns / 1ps

// Channel  Direction  Contents
// s_*      in         tdata[39:0] span_ns, signed frame duration in ns
// m_*      out        tuser[0] accepted, tuser[1] average_valid,
//                     tdata[38:0] average_ns, tdata[76:39] fps_q8, tdata[79:77] zero
//
// Each input word yields exactly one output word. A word is taken, the ring
// and the running sum are updated in a subtract step and an add step, the count
// is checked, then two divisions run on one shared restoring divider, each giving
// DIV_W = max(39 + clog2(SAMPLE_COUNT+1), 38) quotient bits, with a step to collect
// each quotient, a step to start the second division and a step to load the result.
// With the ring still empty the divisions are skipped.
// Reset clears the sum, the count and the write slot; the ring needs no clearing.
// A finished result waits in the output register while the next word is taken;
// the controller only stalls at the end of a word if that register is still full.

module frame_time_moving_average #(
  parameter int SAMPLE_COUNT = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [ftma_pkg::S_TDATA_W-1:0] s_tdata,   // [39:0] span_ns
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [ftma_pkg::M_TDATA_W-1:0] m_tdata,   // [38:0] average_ns, [76:39] fps_q8
  output logic [ftma_pkg::M_TUSER_W-1:0] m_tuser    // [0] accepted, [1] average_valid
);

  import ftma_pkg::*;

  ftma_cmd_t cmd;
  ftma_sts_t sts;

  // The controller walks each word through update and, unless the ring is empty, mean division and rate division.
  ftma_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // The datapath owns the ring, the running sum, the divider and the result register.
  ftma_dp #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .s_tdata(s_tdata),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the frame time moving average block.
`timescale 1ns / 1ps

module tb_top;
  import ftma_pkg::*;

  localparam int HIST_DEPTH   = 64;        // matches the block's default SAMPLE_COUNT
  localparam int RANDOM_WORDS = 650;
  localparam int DRAIN_CYCLES = 200;       // idle cycles run after the last result is checked
  localparam int CYCLE_LIMIT  = 600000;

  typedef struct packed {
    logic             accepted;
    logic             average_valid;
    logic [AVG_W-1:0] average_ns;
    logic [FPS_W-1:0] fps_q8;
  } frame_result_t;

  // Families of spans used for the random part; each run of words sticks to one.
  typedef enum int {STYLE_MIXED, STYLE_FRAME, STYLE_HUGE, STYLE_TINY} span_style_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [M_TUSER_W-1:0] m_tuser;

  // Predictor state: recent spans, their sum, next slot and occupancy.
  logic [AVG_W-1:0] span_hist [HIST_DEPTH];
  logic [45:0]      span_sum = '0;
  logic [5:0]       hist_slot = '0;
  logic [6:0]       span_count = '0;

  logic [SPAN_W-1:0] span_queue [$];
  frame_result_t     expected_results [$];

  int  words_sent = 0;
  int  words_checked = 0;
  int  spans_taken = 0;
  int  spans_ignored = 0;
  int  evictions = 0;
  int  fail_count = 0;
  int  cycle_count = 0;
  int  send_wait = 0;
  int  take_wait = 0;
  bit  calm_stretch = 1'b0;

  frame_time_moving_average dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Updates the running average with one span and returns the word the block
  // should produce for it.
  function automatic frame_result_t track_span(logic [SPAN_W-1:0] span);
    frame_result_t res;
    logic [45:0]   mean_wide;
    logic [63:0]   fps_wide;
    res = '0;
    if (!span[SPAN_W-1] && span != '0) begin
      if (span_count == HIST_DEPTH) begin
        span_sum = span_sum - span_hist[hist_slot];
        evictions++;
      end else begin
        span_count = span_count + 1'b1;
      end
      span_hist[hist_slot] = span[AVG_W-1:0];
      span_sum = span_sum + span[AVG_W-1:0];
      hist_slot = hist_slot + 1'b1;
      res.accepted = 1'b1;
      spans_taken++;
    end else begin
      spans_ignored++;
    end
    if (span_count != 0) begin
      res.average_valid = 1'b1;
      mean_wide = span_sum / span_count;
      res.average_ns = mean_wide[AVG_W-1:0];
      if (mean_wide != 0) begin
        fps_wide = 64'd256_000_000_000 / mean_wide;
        res.fps_q8 = fps_wide[FPS_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [SPAN_W-1:0] random_span(span_style_t style);
    logic [63:0] bits;
    logic [63:0] value;
    int          width;
    bits = {$urandom, $urandom};
    // Roughly one word in eight is a span the block must ignore.
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0: value = '0;
        1: value = '1;
        2: value = 64'h80_0000_0000;
        default: value = {24'd0, 1'b1, bits[38:0]};
      endcase
    end else begin
      case (style)
        STYLE_FRAME: value = $urandom_range(1_000_000, 100_000_000);
        STYLE_HUGE:  value = {25'd0, 1'b1, bits[37:0]};
        STYLE_TINY:  value = $urandom_range(1, 4);
        default: begin
          width = $urandom_range(1, AVG_W);
          value = bits & ((64'd1 << width) - 1);
          if (value == 0) value = 1;
        end
      endcase
    end
    return value[SPAN_W-1:0];
  endfunction

  // Waits are zero throughout a calm stretch, otherwise drawn at random.
  function automatic int draw_wait();
    return calm_stretch ? 0 : $urandom_range(0, 14);
  endfunction

  // Sender: presents queued spans, pausing a random number of cycles after each.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      send_wait = 0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (s_tvalid) begin
        expected_results.push_back(track_span(s_tdata));
        words_sent++;
        if (words_sent % 60 == 0) calm_stretch = ($urandom_range(0, 2) == 0);
        send_wait = draw_wait();
      end
      if (send_wait == 0 && span_queue.size() != 0) begin
        s_tdata  <= span_queue.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        if (send_wait != 0) send_wait--;
      end
    end
  end

  // Receiver: checks every result word against the oldest expectation and
  // drops ready for a random number of cycles after each one.
  always @(posedge clk) begin
    frame_result_t want;
    frame_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
      take_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.accepted      = m_tuser[0];
        got.average_valid = m_tuser[1];
        got.average_ns    = m_tdata[AVG_W-1:0];
        got.fps_q8        = m_tdata[AVG_W+FPS_W-1:AVG_W];
        if (expected_results.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            fail_count++;
          end
          if (got.average_valid !== want.average_valid) begin
            $error("average_valid: expected %0d, got %0d",
                   want.average_valid, got.average_valid);
            fail_count++;
          end
          if (got.average_ns !== want.average_ns) begin
            $error("average_ns: expected %0d, got %0d", want.average_ns, got.average_ns);
            fail_count++;
          end
          if (got.fps_q8 !== want.fps_q8) begin
            $error("fps_q8: expected %0d, got %0d", want.fps_q8, got.fps_q8);
            fail_count++;
          end
        end
        words_checked++;
        take_wait = draw_wait();
      end
      if (take_wait != 0) begin
        m_tready <= 1'b0;
        take_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    span_style_t style;
    int          run_len;
    int          queued;
    // Directed part. The ring is still empty for the first three words, which
    // must all be ignored: zero, the most negative span and minus one.
    span_queue.push_back(40'h00_0000_0000);
    span_queue.push_back(40'h80_0000_0000);
    span_queue.push_back(40'hFF_FFFF_FFFF);
    // Smallest span gives the highest frame rate.
    span_queue.push_back(40'h00_0000_0001);
    span_queue.push_back(40'h00_0000_0000);
    // Largest positive span, then alternating bit patterns.
    span_queue.push_back(40'h7F_FFFF_FFFF);
    span_queue.push_back(40'h55_5555_5555);
    span_queue.push_back(40'h2A_AAAA_AAAA);
    span_queue.push_back(40'hAA_AAAA_AAAA);
    span_queue.push_back(40'hD5_5555_5555);
    span_queue.push_back(40'd16_666_667);
    span_queue.push_back(40'd33_333_333);
    span_queue.push_back(40'd2);
    span_queue.push_back(40'd3);
    span_queue.push_back(40'h7F_FFFF_FFFE);
    span_queue.push_back(40'h40_0000_0000);
    span_queue.push_back(40'hC0_0000_0000);
    span_queue.push_back(40'd1_000_000_000);

    // Random part, in runs of one span family so that the ring fills with
    // like values and the eviction path sees both tiny and huge entries.
    queued = 0;
    while (queued < RANDOM_WORDS) begin
      style = span_style_t'($urandom_range(0, 3));
      run_len = $urandom_range(20, 90);
      for (int i = 0; i < run_len && queued < RANDOM_WORDS; i++) begin
        span_queue.push_back(random_span(style));
        queued++;
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (span_queue.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d words: %0d spans recorded, %0d ignored, %0d ring evictions.",
             words_sent, spans_taken, spans_ignored, evictions);
    $display("Checked %0d result words with %0d mismatches.", words_checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/ftma_pkg.sv
sv/ftma_div.sv
sv/ftma_dp.sv
sv/ftma_ctrl.sv
sv/frame_time_moving_average.sv
tb/sv/tb_top.sv
